/* hdl/msfd_pkg.sv */
package msfd_pkg;

    localparam int NUM_SERVERS = 8;
    localparam int LINE_DEPTH  = 64;
    localparam int TIME_BITS   = 32;

    localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int PTR_W   = $clog2(LINE_DEPTH);
    localparam int CNT_W   = $clog2(LINE_DEPTH + 1);
    localparam int SVC_W   = 16;
    localparam int CFG_W   = 4;
    localparam int ENTRY_W = TIME_BITS + SVC_W;

    localparam logic [CFG_W-1:0] CFG_RST    = 4'd8;
    localparam logic             ACT_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_IDLE_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic                 is_finish;
        logic                 idx_ok;
        logic [SRV_W-1:0]     server;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] arrival;
        logic [SVC_W-1:0]     service;
        logic [TIME_BITS-1:0] start_time;
    } t_cmd;

    typedef struct packed {
        logic                 sched_valid;
        logic [SRV_W-1:0]     sched_server;
        logic [TIME_BITS-1:0] sched_time;
        logic                 wait_valid;
        logic [TIME_BITS-1:0] tis;
        t_status              status;
    } t_result;

endpackage

/* hdl/msfd_front.sv */
module msfd_front
    import msfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_event_time,
    input  logic [31:0] i_job_arrival_time,
    input  logic [15:0] i_job_service_time,
    input  logic [2:0]  i_server_index,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd            = '0;
        n_cmd.is_finish  = (i_action == ACT_FINISH);
        n_cmd.idx_ok     = (32'(i_server_index) < NUM_SERVERS);
        n_cmd.server     = SRV_W'(i_server_index);
        n_cmd.now        = TIME_BITS'(i_event_time);
        n_cmd.arrival    = TIME_BITS'(i_job_arrival_time);
        n_cmd.service    = i_job_service_time;
        n_cmd.start_time = TIME_BITS'(i_event_time) + TIME_BITS'(i_job_service_time);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_cmd   <= n_cmd;
            end else if (i_cmd_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* hdl/msfd_cmdq.sv */
module msfd_cmdq
    import msfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_data
);

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_ent[r_rp];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/msfd_back.sv */
module msfd_back
    import msfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_out
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    t_result              r_out;
    logic                 r_out_valid;
    logic [CFG_W-1:0]     r_servers;
    logic [NUM_SERVERS-1:0] r_busy;
    logic [TIME_BITS-1:0] r_arr [NUM_SERVERS];
    logic [ENTRY_W-1:0]   r_mem [LINE_DEPTH];
    logic [ENTRY_W-1:0]   r_rd;
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;

    logic [NUM_SERVERS-1:0] w_active;
    logic [NUM_SERVERS-1:0] w_free;
    logic                 w_found;
    logic [SRV_W-1:0]     w_pick;
    logic                 w_pop;
    logic                 w_exec;
    logic                 w_start;
    logic                 w_enq;
    logic                 w_take;
    logic                 w_release;
    t_result              w_res;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LINE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_cmd_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_exec      = (r_state == S_EXEC);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        for (int i = 0; i < NUM_SERVERS; i++) begin
            w_active[i] = (i < 32'(r_servers));
        end
        w_free  = ~r_busy & w_active;
        w_found = |w_free;
        w_pick  = '0;
        for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_pick = SRV_W'(i);
            end
        end
    end

    always_comb begin
        w_res     = '0;
        w_start   = 1'b0;
        w_enq     = 1'b0;
        w_take    = 1'b0;
        w_release = 1'b0;
        if (!r_cmd.is_finish) begin
            if (r_count == '0 && w_found) begin
                w_start            = 1'b1;
                w_res.sched_valid  = 1'b1;
                w_res.sched_server = w_pick;
                w_res.sched_time   = r_cmd.start_time;
            end else if (r_count == CNT_W'(LINE_DEPTH)) begin
                w_res.status = ST_FULL;
            end else begin
                w_enq = 1'b1;
            end
        end else if (!r_cmd.idx_ok || !r_busy[r_cmd.server]) begin
            w_res.status = ST_IDLE_ERR;
        end else begin
            w_res.wait_valid = 1'b1;
            w_res.tis        = r_cmd.now - r_arr[r_cmd.server];
            if (r_count != '0 && w_active[r_cmd.server]) begin
                w_take             = 1'b1;
                w_res.sched_valid  = 1'b1;
                w_res.sched_server = r_cmd.server;
                w_res.sched_time   = r_cmd.now + TIME_BITS'(r_rd[SVC_W-1:0]);
            end else begin
                w_release = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_enq) begin
            r_mem[r_tail] <= {r_cmd.arrival, r_cmd.service};
        end
        if (w_pop) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_servers   <= CFG_RST;
            r_busy      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_servers <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_out       <= w_res;
                    if (w_start) begin
                        r_busy[w_pick] <= 1'b1;
                        r_arr[w_pick]  <= r_cmd.arrival;
                    end
                    if (w_enq) begin
                        r_tail  <= ptr_next(r_tail);
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (w_take) begin
                        r_arr[r_cmd.server] <= r_rd[ENTRY_W-1:SVC_W];
                        r_head              <= ptr_next(r_head);
                        r_count             <= r_count - CNT_W'(1);
                    end
                    if (w_release) begin
                        r_busy[r_cmd.server] <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/multi_server_fifo_dispatcher.sv */
// An accepted input beat passes the front register, the command queue, the engine's
// command register and the result register. The engine takes a new beat only when
// done with the last (queue memory read of line head, then pick and state update).
// Reset: synchronous, active low; all servers idle, wait line empty,
// servers_in_use back to 8. No clearing pass; input is taken right after reset.
module multi_server_fifo_dispatcher
    import msfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_event_time,
    input  logic [31:0] i_job_arrival_time,
    input  logic [15:0] i_job_service_time,
    input  logic [2:0]  i_server_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_schedule_valid,
    output logic [2:0]  o_schedule_server,
    output logic [31:0] o_schedule_time,
    output logic        o_wait_valid,
    output logic [31:0] o_time_in_system,
    output logic [1:0]  o_status
);

    logic    w_f_valid;
    logic    w_f_ready;
    t_cmd    w_f_cmd;
    logic    w_q_valid;
    logic    w_q_ready;
    t_cmd    w_q_cmd;
    t_result w_res;

    msfd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_event_time       (i_event_time),
        .i_job_arrival_time (i_job_arrival_time),
        .i_job_service_time (i_job_service_time),
        .i_server_index     (i_server_index),
        .o_cmd_valid        (w_f_valid),
        .i_cmd_ready        (w_f_ready),
        .o_cmd              (w_f_cmd)
    );

    msfd_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .o_wr_ready (w_f_ready),
        .i_wr_data  (w_f_cmd),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_data  (w_q_cmd)
    );

    msfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_data  (CFG_W'(i_cfg_wr_data)),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out       (w_res)
    );

    assign o_schedule_valid  = w_res.sched_valid;
    assign o_schedule_server = 3'(w_res.sched_server);
    assign o_schedule_time   = 32'(w_res.sched_time);
    assign o_wait_valid      = w_res.wait_valid;
    assign o_time_in_system  = 32'(w_res.tis);
    assign o_status          = w_res.status;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid or input stalled right after reset");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (!o_schedule_valid && !o_wait_valid && o_schedule_time == 32'd0 &&
         o_time_in_system == 32'd0 && o_schedule_server == 3'd0))
        else $error("error result carries nonzero fields");

    a_one_per_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_q_ready) |=> !w_q_ready)
        else $error("dispatch engine took two beats back to back");

    a_wait_has_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wait_valid) |-> o_status == ST_OK)
        else $error("completion reported with error status");

endmodule

/* sim/multi_server_fifo_dispatcher_tb.sv */
module multi_server_fifo_dispatcher_tb;
    import msfd_pkg::*;

    localparam logic ACT_ARRIVE   = ~ACT_FINISH;
    localparam int   QUIET_LIMIT  = 3000;
    localparam int   SETTLE_TICKS = 8;
    localparam int   HOLD_CYCLES  = 400;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_cfg_wr_en        = 1'b0;
    logic [3:0]  i_cfg_wr_data      = '0;
    logic        i_valid            = 1'b0;
    logic        o_ready;
    logic        i_action           = 1'b0;
    logic [31:0] i_event_time       = '0;
    logic [31:0] i_job_arrival_time = '0;
    logic [15:0] i_job_service_time = '0;
    logic [2:0]  i_server_index     = '0;
    logic        o_valid;
    logic        i_ready            = 1'b0;
    logic        o_schedule_valid;
    logic [2:0]  o_schedule_server;
    logic [31:0] o_schedule_time;
    logic        o_wait_valid;
    logic [31:0] o_time_in_system;
    logic [1:0]  o_status;

    t_result     dispatch_results_due[$];
    logic [3:0]  servers_in_use = CFG_RST;
    logic        srv_busy [NUM_SERVERS] = '{default: 1'b0};
    logic [31:0] srv_job_arrival [NUM_SERVERS];
    logic [31:0] line_arrival [LINE_DEPTH];
    logic [15:0] line_service [LINE_DEPTH];
    int          line_head    = 0;
    int          line_tail    = 0;
    int          line_count   = 0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    bit          offering     = 1'b0;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          pattern_left = 0;
    int          ready_pct    = 100;
    logic [31:0] sim_now      = 32'hFFFF_F000;

    multi_server_fifo_dispatcher uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_event_time       (i_event_time),
        .i_job_arrival_time (i_job_arrival_time),
        .i_job_service_time (i_job_service_time),
        .i_server_index     (i_server_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_schedule_valid   (o_schedule_valid),
        .o_schedule_server  (o_schedule_server),
        .o_schedule_time    (o_schedule_time),
        .o_wait_valid       (o_wait_valid),
        .o_time_in_system   (o_time_in_system),
        .o_status           (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_result predict_dispatch(input logic act, input logic [31:0] ev,
            input logic [31:0] arr, input logic [15:0] svc, input logic [2:0] srv);
        t_result r;
        int      active;
        int      pick;
        int      i;
        r = '0;
        r.status = ST_OK;
        active = (servers_in_use < NUM_SERVERS) ? int'(servers_in_use) : NUM_SERVERS;
        if (act == ACT_FINISH) begin
            if (!srv_busy[srv]) begin
                r.status = ST_IDLE_ERR;
            end else begin
                r.wait_valid = 1'b1;
                r.tis = ev - srv_job_arrival[srv];
                if (line_count > 0 && srv < active) begin
                    r.sched_valid  = 1'b1;
                    r.sched_server = srv;
                    r.sched_time   = ev + {16'd0, line_service[line_head]};
                    srv_job_arrival[srv] = line_arrival[line_head];
                    line_head = (line_head + 1) % LINE_DEPTH;
                    line_count--;
                end else begin
                    srv_busy[srv] = 1'b0;
                end
            end
            return r;
        end
        pick = -1;
        if (line_count == 0) begin
            for (i = active - 1; i >= 0; i--) begin
                if (!srv_busy[i]) pick = i;
            end
        end
        if (pick >= 0) begin
            srv_busy[pick]        = 1'b1;
            srv_job_arrival[pick] = arr;
            r.sched_valid  = 1'b1;
            r.sched_server = SRV_W'(pick);
            r.sched_time   = ev + {16'd0, svc};
        end else if (line_count >= LINE_DEPTH) begin
            r.status = ST_FULL;
        end else begin
            line_arrival[line_tail] = arr;
            line_service[line_tail] = svc;
            line_tail = (line_tail + 1) % LINE_DEPTH;
            line_count++;
        end
        return r;
    endfunction

    task automatic send_job(input logic act, input logic [31:0] ev, input logic [31:0] arr,
            input logic [15:0] svc, input logic [2:0] srv);
        t_result due;
        if (burst_left == 0) begin
            if (offering) i_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        i_valid            <= 1'b1;
        i_action           <= act;
        i_event_time       <= ev;
        i_job_arrival_time <= arr;
        i_job_service_time <= svc;
        i_server_index     <= srv;
        offering = 1'b1;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        due = predict_dispatch(act, ev, arr, svc, srv);
        dispatch_results_due.insert(dispatch_results_due.size(), due);
        burst_left--;
    endtask

    // drop valid, drain every expected beat, then let the pipeline go quiet
    task automatic settle_block();
        if (offering) i_valid <= 1'b0;
        offering   = 1'b0;
        burst_left = 0;
        while (dispatch_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_servers_in_use(input logic [3:0] value);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        servers_in_use = value;
    endtask

    task automatic run_traffic(input int count, input int arrive_pct);
        logic [31:0] ev;
        logic [31:0] arr;
        logic [15:0] svc;
        logic [2:0]  srv;
        int          k;
        repeat (count) begin
            sim_now += $urandom_range(0, 40);
            ev = ($urandom_range(0, 15) == 0) ? $urandom : sim_now;
            if ($urandom_range(0, 99) < arrive_pct) begin
                arr = ($urandom_range(0, 7) == 0) ? $urandom : ev - $urandom_range(0, 25);
                svc = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 400));
                send_job(ACT_ARRIVE, ev, arr, svc, 3'($urandom));
            end else begin
                srv = 3'($urandom);
                if ($urandom_range(0, 9) != 0) begin
                    for (k = 0; k < 32 && !srv_busy[srv]; k++) srv = 3'($urandom);
                end
                send_job(ACT_FINISH, ev, $urandom, 16'($urandom), srv);
            end
        end
    endtask

    task automatic test_dispatch_extremes();
        int k;
        send_job(ACT_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
        send_job(ACT_ARRIVE, 32'h0, 32'h0, 16'h0, 3'd7);
        send_job(ACT_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
        for (k = 2; k < NUM_SERVERS; k++) begin
            send_job(ACT_ARRIVE, 32'd100 + k, 32'd90, 16'(k * 3), 3'(k));
        end
        send_job(ACT_ARRIVE, 32'd200, 32'd150, 16'd20, 3'd0);
        send_job(ACT_ARRIVE, 32'd210, 32'hFFFF_FFF0, 16'hFFFF, 3'd0);
        send_job(ACT_FINISH, 32'd5, 32'h0, 16'h0, 3'd1);
        send_job(ACT_FINISH, 32'hFFFF_FFFF, 32'h0, 16'h0, 3'd0);
        send_job(ACT_ARRIVE, 32'd300, 32'd300, 16'd1, 3'd0);
        send_job(ACT_FINISH, 32'd400, 32'h0, 16'h0, 3'd7);
    endtask

    task automatic test_servers_in_use_change();
        set_servers_in_use(4'd2);
        send_job(ACT_ARRIVE, 32'd500, 32'd480, 16'd7, 3'd0);
        send_job(ACT_FINISH, 32'd510, 32'h0, 16'h0, 3'd5);
        set_servers_in_use(4'd8);
        send_job(ACT_ARRIVE, 32'd520, 32'd515, 16'd9, 3'd0);
        send_job(ACT_FINISH, 32'd530, 32'h0, 16'h0, 3'd0);
        send_job(ACT_FINISH, 32'd540, 32'h0, 16'h0, 3'd1);
        send_job(ACT_ARRIVE, 32'd550, 32'd550, 16'd3, 3'd0);
        send_job(ACT_FINISH, 32'd560, 32'h0, 16'h0, 3'd5);
        send_job(ACT_FINISH, 32'd570, 32'h0, 16'h0, 3'd5);
    endtask

    task automatic test_line_full();
        set_servers_in_use(4'd1);
        run_traffic(LINE_DEPTH + 6, 100);
        while (srv_busy[0]) begin
            sim_now += $urandom_range(0, 40);
            send_job(ACT_FINISH, sim_now, $urandom, 16'($urandom), 3'd0);
        end
    endtask

    task automatic test_backpressure();
        set_servers_in_use(4'd8);
        hold_request = HOLD_CYCLES;
        run_traffic(150, 50);
    endtask

    task automatic test_random_phases();
        set_servers_in_use(4'd3);
        run_traffic(150, 55);
        set_servers_in_use(4'd15);
        run_traffic(150, 60);
        set_servers_in_use(4'd1);
        run_traffic(120, 60);
        set_servers_in_use(4'd8);
        run_traffic(120, 75);
        set_servers_in_use(4'd0);
        run_traffic(40, 100);
        set_servers_in_use(4'd5);
        run_traffic(150, 40);
        set_servers_in_use(4'd9);
        run_traffic(100, 50);
        set_servers_in_use(4'd2);
        run_traffic(120, 50);
        set_servers_in_use(4'd8);
        run_traffic(100, 50);
    endtask

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                pattern_left = $urandom_range(4, 60);
            end
            pattern_left--;
            i_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            seen = {o_schedule_valid, o_schedule_server, o_schedule_time,
                    o_wait_valid, o_time_in_system, o_status};
            if (dispatch_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at %0t: %h", $time, seen);
            end else begin
                want = dispatch_results_due.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t", $time);
                        $display("  expected sv=%b srv=%0d st=%h wv=%b tis=%h status=%0d",
                                 want.sched_valid, want.sched_server, want.sched_time,
                                 want.wait_valid, want.tis, want.status);
                        $display("  actual   sv=%b srv=%0d st=%h wv=%b tis=%h status=%0d",
                                 o_schedule_valid, o_schedule_server, o_schedule_time,
                                 o_wait_valid, o_time_in_system, o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multi_server_fifo_dispatcher_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_dispatch_extremes();
        test_servers_in_use_change();
        test_line_full();
        test_backpressure();
        test_random_phases();
        settle_block();
        if (mismatches == 0)
            $display("multi_server_fifo_dispatcher_tb passed");
        else
            $display("multi_server_fifo_dispatcher_tb failed");
        $finish;
    end

endmodule

/* files.f */
hdl/msfd_pkg.sv
hdl/msfd_front.sv
hdl/msfd_cmdq.sv
hdl/msfd_back.sv
hdl/multi_server_fifo_dispatcher.sv
sim/multi_server_fifo_dispatcher_tb.sv
